>>> rtl/iag_pkg.sv
// Shared types and constants for the accel-to-gyro resampler.
package iag_pkg;

	localparam int TIME_W = 48;
	localparam int AXIS_W = 32;
	localparam int NUM_AXES = 3;
	localparam int MAX_RESULTS = 16;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic KIND_GYRO = 1'b0;
	localparam logic KIND_ACCEL = 1'b1;

	// One queued gyro sample
	typedef struct packed {
		logic [TIME_W-1:0] sample_time;
		logic [AXIS_W-1:0] gx;
		logic [AXIS_W-1:0] gy;
		logic [AXIS_W-1:0] gz;
	} gyro_entry_t;

endpackage

>>> rtl/imu_accel_to_gyro_resampler.sv
// Top level of the accel-to-gyro resampler: gyro queue, sequencer, interpolation.
//
// Input channel (in_valid/in_ready): one request per sensor sample. kind selects
// gyro (queued, no result) or accel (becomes the newest accel sample and flushes
// the queue). Output channel (out_valid/out_ready): one request per flushed gyro
// sample with accel interpolated at its time; last_of_run marks the final one of
// a flush and gyro_dropped reports queue overflow since the previous flush.
// At most MAX_RESULTS gyro samples leave per accel sample; the rest wait.
// Each emitted result needs one queue read when accel is held; when it is
// interpolated, the queue read is followed by a serial divide of one quotient
// bit per cycle, then one shared multiplier used for the three axes in turn.
// Input is taken only while no flush is running. When the receiver stalls,
// the result is held and the flush waits.
// Reset empties the queue and forgets all accel samples; the queue memory
// itself is not cleared.
module imu_accel_to_gyro_resampler import iag_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic [TIME_W-1:0]        sample_time,
	input  logic signed [AXIS_W-1:0] axis_x,
	input  logic signed [AXIS_W-1:0] axis_y,
	input  logic signed [AXIS_W-1:0] axis_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [TIME_W-1:0]        gyro_time,
	output logic signed [AXIS_W-1:0] gyro_x,
	output logic signed [AXIS_W-1:0] gyro_y,
	output logic signed [AXIS_W-1:0] gyro_z,
	output logic signed [AXIS_W-1:0] accel_x,
	output logic signed [AXIS_W-1:0] accel_y,
	output logic signed [AXIS_W-1:0] accel_z,
	output logic                     last_of_run,
	output logic                     gyro_dropped
);

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int EMIT_W = $clog2(MAX_RESULTS);
	localparam int AX_W = $clog2(NUM_AXES);
	localparam int PROD_W = AXIS_W + FRACTION_BITS + 3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CALC,
		S_DIV,
		S_MUL,
		S_ADD,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [EMIT_W-1:0] emit_q;
	logic [AX_W-1:0]   axis_q;
	logic              drop_q;
	logic              accel_seen_q;
	logic              older_valid_q;

	gyro_entry_t       mem_q [QUEUE_DEPTH];
	gyro_entry_t       rd_q;
	gyro_entry_t       wr_entry;

	logic [TIME_W-1:0] newest_time_q;
	logic [TIME_W-1:0] older_time_q;
	logic [AXIS_W-1:0] newest_q [NUM_AXES];
	logic [AXIS_W-1:0] older_q [NUM_AXES];
	logic [AXIS_W-1:0] acc_q [NUM_AXES];
	logic signed [PROD_W-1:0] prod_s1;

	logic              in_acc;
	logic              out_acc;
	logic              queue_full;
	logic              wr_en;
	logic [SUM_W-1:0]  tail_sum;
	logic [SUM_W-1:0]  tail_wrap;
	logic [IDX_W-1:0]  tail_idx;
	logic [IDX_W-1:0]  head_next;
	logic              run_last;
	logic              use_newest;
	logic              use_interp;
	logic              div_start;
	logic              div_done;
	logic [FRACTION_BITS:0]   div_quot;
	logic [TIME_W-1:0]        div_n;
	logic [TIME_W-1:0]        div_m;
	logic signed [AXIS_W:0]   diff_axis;
	logic signed [FRACTION_BITS+1:0] fac;
	logic signed [PROD_W-1:0] half;
	logic signed [PROD_W-1:0] rnd_sum;
	logic signed [PROD_W-1:0] rnd_sh;
	logic [AXIS_W:0]          lerp;

	// Handshakes and queue pointers
	always_comb begin
		in_acc     = in_valid && in_ready;
		out_acc    = out_valid && out_ready;
		queue_full = count_q == CNT_W'(QUEUE_DEPTH);
		wr_en      = in_acc && (kind == KIND_GYRO) && !queue_full;
		tail_sum   = SUM_W'(head_q) + SUM_W'(count_q);
		tail_wrap  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
			tail_sum - SUM_W'(QUEUE_DEPTH) : tail_sum;
		tail_idx   = tail_wrap[IDX_W-1:0];
		head_next  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		run_last   = (count_q == CNT_W'(1)) || (emit_q == EMIT_W'(MAX_RESULTS - 1));
		wr_entry   = '{sample_time: sample_time, gx: axis_x, gy: axis_y, gz: axis_z};
	end

	// Where the gyro time falls against the two accel samples
	always_comb begin
		use_newest = !older_valid_q || (rd_q.sample_time > newest_time_q);
		use_interp = !use_newest && (rd_q.sample_time > older_time_q);
		div_start  = (state_q == S_CALC) && use_interp;
		div_n      = rd_q.sample_time - older_time_q;
		div_m      = newest_time_q - older_time_q;
	end

	// Per-axis interpolation through one shared multiplier
	always_comb begin
		diff_axis = $signed({newest_q[axis_q][AXIS_W-1], newest_q[axis_q]}) -
			$signed({older_q[axis_q][AXIS_W-1], older_q[axis_q]});
		fac     = $signed({1'b0, div_quot});
		half    = {{(PROD_W - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};
		rnd_sum = prod_s1 + half;
		rnd_sh  = rnd_sum >>> FRACTION_BITS;
		lerp    = rnd_sh[AXIS_W:0] + {older_q[axis_q][AXIS_W-1], older_q[axis_q]};
	end

	iag_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_n),
		.divisor(div_m),
		.done(div_done),
		.quotient(div_quot)
	);

	// Gyro queue memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[tail_idx] <= wr_entry;
		end
		if (state_q == S_READ) begin
			rd_q <= mem_q[head_q];
		end
	end

	// Sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			emit_q        <= '0;
			axis_q        <= '0;
			drop_q        <= 1'b0;
			accel_seen_q  <= 1'b0;
			older_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (kind == KIND_GYRO) begin
							if (queue_full) begin
								drop_q <= 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end else begin
							older_valid_q <= accel_seen_q;
							accel_seen_q  <= 1'b1;
							emit_q        <= '0;
							if (count_q != '0) begin
								state_q <= S_READ;
							end
						end
					end
				end
				S_READ: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					axis_q  <= '0;
					state_q <= use_interp ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					if (axis_q == AX_W'(NUM_AXES - 1)) begin
						state_q <= S_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
						if (run_last) begin
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							emit_q  <= emit_q + 1'b1;
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Accel samples, product and result data
	always_ff @(posedge clk) begin
		if (in_acc && (kind == KIND_ACCEL)) begin
			older_time_q  <= newest_time_q;
			newest_time_q <= sample_time;
			for (int i = 0; i < NUM_AXES; i++) begin
				older_q[i] <= newest_q[i];
			end
			newest_q[0] <= axis_x;
			newest_q[1] <= axis_y;
			newest_q[2] <= axis_z;
		end
		if ((state_q == S_CALC) && !use_interp) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				acc_q[i] <= use_newest ? newest_q[i] : older_q[i];
			end
		end
		if (state_q == S_MUL) begin
			prod_s1 <= PROD_W'(diff_axis) * PROD_W'(fac);
		end
		if (state_q == S_ADD) begin
			acc_q[axis_q] <= lerp[AXIS_W-1:0];
		end
	end

	assign in_ready     = state_q == S_IDLE;
	assign out_valid    = state_q == S_OUT;
	assign gyro_time    = rd_q.sample_time;
	assign gyro_x       = rd_q.gx;
	assign gyro_y       = rd_q.gy;
	assign gyro_z       = rd_q.gz;
	assign accel_x      = acc_q[0];
	assign accel_y      = acc_q[1];
	assign accel_z      = acc_q[2];
	assign last_of_run  = run_last;
	assign gyro_dropped = drop_q;

	// Queue never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// A result is only shown while the queue still holds its sample
	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("result shown with empty queue");

	// The final result of a flush returns the block to taking input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_of_run) |=> in_ready)
		else $error("flush did not end after last result");

	// A gyro sample offered to a full queue raises the drop flag
	a_drop_set: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (kind == KIND_GYRO) && queue_full) |=> drop_q)
		else $error("overflow not flagged");

	// Divider completion moves on to the multiply
	a_div_mul: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && div_done) |=> (state_q == S_MUL))
		else $error("divider result not consumed");

endmodule

>>> rtl/iag_div.sv
// Serial restoring divider: floor(n * 2^FRACTION_BITS / m) for 0 < n <= m.
module iag_div import iag_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [TIME_W-1:0]        dividend,
	input  logic [TIME_W-1:0]        divisor,
	output logic                     done,
	output logic [FRACTION_BITS:0]   quotient
);

	localparam int Q_W = FRACTION_BITS + 1;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W:0]   rem_q;
	logic [TIME_W-1:0] dsr_q;
	logic [Q_W-1:0]    quo_q;
	logic [TIME_W:0]   trial;
	logic [TIME_W:0]   diff;
	logic              ge;

	// First step compares the plain remainder, later steps the doubled one
	always_comb begin
		trial = (cnt_q == '0) ? rem_q : {rem_q[TIME_W-1:0], 1'b0};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	// Step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient, one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff : trial;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

>>> tb/sv/aligned_sample_checker.sv
// Checker for the accel-to-gyro resampler: predicts aligned results and compares them.
`timescale 1ns / 1ps
module aligned_sample_checker import iag_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     kind,
	input  logic [TIME_W-1:0]        sample_time,
	input  logic signed [AXIS_W-1:0] axis_x,
	input  logic signed [AXIS_W-1:0] axis_y,
	input  logic signed [AXIS_W-1:0] axis_z,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic [TIME_W-1:0]        gyro_time,
	input  logic signed [AXIS_W-1:0] gyro_x,
	input  logic signed [AXIS_W-1:0] gyro_y,
	input  logic signed [AXIS_W-1:0] gyro_z,
	input  logic signed [AXIS_W-1:0] accel_x,
	input  logic signed [AXIS_W-1:0] accel_y,
	input  logic signed [AXIS_W-1:0] accel_z,
	input  logic                     last_of_run,
	input  logic                     gyro_dropped,
	output int                       mismatches,
	output int                       results_due
);

	localparam int FB = FRACTION_BITS_DEF;

	// One gyro sample with accel aligned to its time
	typedef struct {
		logic [TIME_W-1:0]        gyro_time;
		logic signed [AXIS_W-1:0] gx;
		logic signed [AXIS_W-1:0] gy;
		logic signed [AXIS_W-1:0] gz;
		logic signed [AXIS_W-1:0] ax;
		logic signed [AXIS_W-1:0] ay;
		logic signed [AXIS_W-1:0] az;
		logic                     last;
		logic                     dropped;
	} aligned_t;

	// Predicted block state
	gyro_entry_t              gyro_backlog[$];
	aligned_t                 aligned_due[$];
	logic signed [AXIS_W-1:0] newest_acc [NUM_AXES];
	logic signed [AXIS_W-1:0] older_acc [NUM_AXES];
	logic [TIME_W-1:0]        newest_t;
	logic [TIME_W-1:0]        older_t;
	logic                     accel_seen;
	logic                     older_ok;
	logic                     overflowed;

	// floor(span_at * 2^FB / span_all), span_at <= span_all
	function automatic logic [FB:0] lerp_factor(logic [TIME_W-1:0] span_at,
			logic [TIME_W-1:0] span_all);
		logic [TIME_W+FB-1:0] num;
		num = {span_at, {FB{1'b0}}};
		return num / span_all;
	endfunction

	// a0 + round((a1 - a0) * f / 2^FB), ties toward +inf
	function automatic logic signed [AXIS_W-1:0] lerp_axis(logic signed [AXIS_W-1:0] a0,
			logic signed [AXIS_W-1:0] a1, logic [FB:0] f);
		longint d;
		longint p;
		d = longint'(a1) - longint'(a0);
		p = d * longint'(f) + (longint'(1) <<< (FB - 1));
		return AXIS_W'(longint'(a0) + (p >>> FB));
	endfunction

	function automatic void check_field(string name, logic [TIME_W-1:0] want,
			logic [TIME_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Update the predicted state with one accepted sample
	task automatic align_step(input logic k, input logic [TIME_W-1:0] t,
			input logic signed [AXIS_W-1:0] x, input logic signed [AXIS_W-1:0] y,
			input logic signed [AXIS_W-1:0] z);
		gyro_entry_t              g;
		aligned_t                 r;
		logic signed [AXIS_W-1:0] acc [NUM_AXES];
		logic [FB:0]              f;
		int                       n;
		if (k == KIND_GYRO) begin
			if (gyro_backlog.size() >= QUEUE_DEPTH_DEF) begin
				overflowed = 1'b1;
			end else begin
				g.sample_time = t;
				g.gx = x;
				g.gy = y;
				g.gz = z;
				gyro_backlog = {gyro_backlog, g};
			end
		end else begin
			// shift newest accel into the older slot
			older_acc = newest_acc;
			older_t = newest_t;
			older_ok = accel_seen;
			newest_acc[0] = x;
			newest_acc[1] = y;
			newest_acc[2] = z;
			newest_t = t;
			accel_seen = 1'b1;
			n = 0;
			while (gyro_backlog.size() > 0 && n < MAX_RESULTS) begin
				g = gyro_backlog.pop_front();
				if (!older_ok || g.sample_time > newest_t) begin
					acc = newest_acc;
				end else if (g.sample_time > older_t) begin
					f = lerp_factor(g.sample_time - older_t, newest_t - older_t);
					for (int a = 0; a < NUM_AXES; a++)
						acc[a] = lerp_axis(older_acc[a], newest_acc[a], f);
				end else begin
					acc = older_acc;
				end
				r.gyro_time = g.sample_time;
				r.gx = g.gx;
				r.gy = g.gy;
				r.gz = g.gz;
				r.ax = acc[0];
				r.ay = acc[1];
				r.az = acc[2];
				r.last = (gyro_backlog.size() == 0) || (n + 1 == MAX_RESULTS);
				r.dropped = overflowed;
				aligned_due = {aligned_due, r};
				n++;
			end
			if (n > 0)
				overflowed = 1'b0;
		end
	endtask

	// Watch both channels
	always @(posedge clk or negedge arst_n) begin
		aligned_t r;
		if (!arst_n) begin
			gyro_backlog.delete();
			aligned_due.delete();
			for (int a = 0; a < NUM_AXES; a++) begin
				newest_acc[a] = '0;
				older_acc[a] = '0;
			end
			newest_t = '0;
			older_t = '0;
			accel_seen = 1'b0;
			older_ok = 1'b0;
			overflowed = 1'b0;
			results_due = 0;
		end else begin
			if (in_valid && in_ready)
				align_step(kind, sample_time, axis_x, axis_y, axis_z);
			if (out_valid && out_ready) begin
				if (aligned_due.size() == 0) begin
					$error("unexpected result request, gyro_time %0h", gyro_time);
					mismatches++;
				end else begin
					r = aligned_due.pop_front();
					check_field("gyro_time", r.gyro_time, gyro_time);
					check_field("gyro_x", r.gx, gyro_x);
					check_field("gyro_y", r.gy, gyro_y);
					check_field("gyro_z", r.gz, gyro_z);
					check_field("accel_x", r.ax, accel_x);
					check_field("accel_y", r.ay, accel_y);
					check_field("accel_z", r.az, accel_z);
					check_field("last_of_run", r.last, last_of_run);
					check_field("gyro_dropped", r.dropped, gyro_dropped);
				end
			end
			results_due = aligned_due.size();
		end
	end

endmodule

>>> tb/sv/imu_accel_to_gyro_resampler_tb.sv
// Top of the resampler testbench: clock, reset, sample stimulus, receiver and verdict.
`timescale 1ns / 1ps
module imu_accel_to_gyro_resampler_tb import iag_pkg::*; ();

	localparam int RANDOM_ITEMS = 240;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 500;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic                     kind;
	logic [TIME_W-1:0]        sample_time;
	logic signed [AXIS_W-1:0] axis_x;
	logic signed [AXIS_W-1:0] axis_y;
	logic signed [AXIS_W-1:0] axis_z;
	logic                     out_valid;
	logic                     out_ready;
	logic [TIME_W-1:0]        gyro_time;
	logic signed [AXIS_W-1:0] gyro_x;
	logic signed [AXIS_W-1:0] gyro_y;
	logic signed [AXIS_W-1:0] gyro_z;
	logic signed [AXIS_W-1:0] accel_x;
	logic signed [AXIS_W-1:0] accel_y;
	logic signed [AXIS_W-1:0] accel_z;
	logic                     last_of_run;
	logic                     gyro_dropped;
	int                       mismatches;
	int                       results_due;

	// Control flags for the sender and the receiver
	logic calm_tail = 1'b0;
	logic squeeze = 1'b0;
	logic squeeze_done = 1'b0;
	logic idle_window = 1'b1;
	logic stall_window = 1'b1;

	imu_accel_to_gyro_resampler dut (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .sample_time,
		.axis_x, .axis_y, .axis_z, .out_valid, .out_ready, .gyro_time,
		.gyro_x, .gyro_y, .gyro_z, .accel_x, .accel_y, .accel_z,
		.last_of_run, .gyro_dropped
	);

	aligned_sample_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .kind, .sample_time,
		.axis_x, .axis_y, .axis_z, .out_valid, .out_ready, .gyro_time,
		.gyro_x, .gyro_y, .gyro_z, .accel_x, .accel_y, .accel_z,
		.last_of_run, .gyro_dropped, .mismatches, .results_due
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit
	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

	// Axis values weighted toward the extremes
	function automatic logic [AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// Random idle burst on the input side
	task automatic pause_sender();
		if (!calm_tail && idle_window && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
	endtask

	// Offer one sample request and wait until it is taken
	task automatic send_sample(input logic k, input logic [TIME_W-1:0] t,
			input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
			input logic [AXIS_W-1:0] z);
		pause_sender();
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		sample_time <= t;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver: random stalls, one long hold-off, none in the tail
	initial begin
		int cycles;
		out_ready = 1'b0;
		cycles = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			cycles++;
			if (cycles % 50 == 0)
				stall_window = ($urandom_range(0, 2) != 0);
			if (squeeze && !squeeze_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				squeeze_done = 1'b1;
			end else if (!calm_tail && stall_window && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(0, 10)) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		logic [TIME_W-1:0] clock_us;
		int                sent;
		int                len;
		int                pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_GYRO;
		sample_time = '0;
		axis_x = '0;
		axis_y = '0;
		axis_z = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// gyro before any accel: newest held, extreme times and axes
		send_sample(KIND_GYRO, 48'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		send_sample(KIND_GYRO, 48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'hFFFF_FFFF);
		send_sample(KIND_ACCEL, 48'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
		// accel with empty queue
		send_sample(KIND_ACCEL, 48'd2000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		// at older time, inside, at newest time, past newest
		send_sample(KIND_GYRO, 48'd2000, rand_axis(), rand_axis(), rand_axis());
		send_sample(KIND_GYRO, 48'd2500, rand_axis(), rand_axis(), rand_axis());
		send_sample(KIND_GYRO, 48'd3000, rand_axis(), rand_axis(), rand_axis());
		send_sample(KIND_GYRO, 48'd3001, rand_axis(), rand_axis(), rand_axis());
		// fill the queue, the last one is dropped
		for (int i = 0; i < 13; i++)
			send_sample(KIND_GYRO, 48'(2100 + 20 * i), rand_axis(), rand_axis(), rand_axis());
		send_sample(KIND_ACCEL, 48'd3000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd12345);
		// drop flag cleared on the next run
		send_sample(KIND_GYRO, 48'd3500, rand_axis(), rand_axis(), rand_axis());
		send_sample(KIND_ACCEL, 48'd4000, rand_axis(), rand_axis(), rand_axis());

		// random part
		clock_us = 48'd5000;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_window = ($urandom_range(0, 2) != 0);
			if (sent >= RANDOM_ITEMS - 40)
				calm_tail = 1'b1;
			if (sent >= 90)
				squeeze = 1'b1;
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				// ordered sensor stream, sometimes from a new base time
				if ($urandom_range(0, 3) == 0)
					clock_us = {16'($urandom), 32'($urandom)};
				len = $urandom_range(6, 20);
				for (int i = 0; i < len; i++) begin
					clock_us += 48'($urandom_range(0, 400));
					send_sample(($urandom_range(0, 3) == 0) ? KIND_ACCEL : KIND_GYRO,
						clock_us, rand_axis(), rand_axis(), rand_axis());
					sent++;
				end
			end else if (pick == 7) begin
				// gyro burst that can overflow the queue, then a flush
				len = $urandom_range(14, 20);
				for (int i = 0; i < len; i++) begin
					clock_us += 48'($urandom_range(1, 50));
					send_sample(KIND_GYRO, clock_us, rand_axis(), rand_axis(), rand_axis());
					sent++;
				end
				clock_us += 48'($urandom_range(0, 200));
				send_sample(KIND_ACCEL, clock_us, rand_axis(), rand_axis(), rand_axis());
				sent++;
			end else begin
				// noise: any kind, any time
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					send_sample(1'($urandom), {16'($urandom), 32'($urandom)},
						$urandom, $urandom, $urandom);
					sent++;
				end
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
